// ===== rtl/sha256d_pkg.sv =====
package sha256d_pkg;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IDX_W     = 3;

    localparam logic       ACT_ABSORB = 1'b0;
    localparam logic       ACT_FINISH = 1'b1;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] SCHED_POS  = 6'd16;
    localparam logic [2:0] LAST_IDX   = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef logic [7:0][31:0] words8_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] initial_hash(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6A09E667;
            3'd1:    r = 32'hBB67AE85;
            3'd2:    r = 32'h3C6EF372;
            3'd3:    r = 32'hA54FF53A;
            3'd4:    r = 32'h510E527F;
            3'd5:    r = 32'h9B05688C;
            3'd6:    r = 32'h1F83D9AB;
            default: r = 32'h5BE0CD19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] r;
        case (t)
            6'd0:    r = 32'h428A2F98;
            6'd1:    r = 32'h71374491;
            6'd2:    r = 32'hB5C0FBCF;
            6'd3:    r = 32'hE9B5DBA5;
            6'd4:    r = 32'h3956C25B;
            6'd5:    r = 32'h59F111F1;
            6'd6:    r = 32'h923F82A4;
            6'd7:    r = 32'hAB1C5ED5;
            6'd8:    r = 32'hD807AA98;
            6'd9:    r = 32'h12835B01;
            6'd10:   r = 32'h243185BE;
            6'd11:   r = 32'h550C7DC3;
            6'd12:   r = 32'h72BE5D74;
            6'd13:   r = 32'h80DEB1FE;
            6'd14:   r = 32'h9BDC06A7;
            6'd15:   r = 32'hC19BF174;
            6'd16:   r = 32'hE49B69C1;
            6'd17:   r = 32'hEFBE4786;
            6'd18:   r = 32'h0FC19DC6;
            6'd19:   r = 32'h240CA1CC;
            6'd20:   r = 32'h2DE92C6F;
            6'd21:   r = 32'h4A7484AA;
            6'd22:   r = 32'h5CB0A9DC;
            6'd23:   r = 32'h76F988DA;
            6'd24:   r = 32'h983E5152;
            6'd25:   r = 32'hA831C66D;
            6'd26:   r = 32'hB00327C8;
            6'd27:   r = 32'hBF597FC7;
            6'd28:   r = 32'hC6E00BF3;
            6'd29:   r = 32'hD5A79147;
            6'd30:   r = 32'h06CA6351;
            6'd31:   r = 32'h14292967;
            6'd32:   r = 32'h27B70A85;
            6'd33:   r = 32'h2E1B2138;
            6'd34:   r = 32'h4D2C6DFC;
            6'd35:   r = 32'h53380D13;
            6'd36:   r = 32'h650A7354;
            6'd37:   r = 32'h766A0ABB;
            6'd38:   r = 32'h81C2C92E;
            6'd39:   r = 32'h92722C85;
            6'd40:   r = 32'hA2BFE8A1;
            6'd41:   r = 32'hA81A664B;
            6'd42:   r = 32'hC24B8B70;
            6'd43:   r = 32'hC76C51A3;
            6'd44:   r = 32'hD192E819;
            6'd45:   r = 32'hD6990624;
            6'd46:   r = 32'hF40E3585;
            6'd47:   r = 32'h106AA070;
            6'd48:   r = 32'h19A4C116;
            6'd49:   r = 32'h1E376C08;
            6'd50:   r = 32'h2748774C;
            6'd51:   r = 32'h34B0BCB5;
            6'd52:   r = 32'h391C0CB3;
            6'd53:   r = 32'h4ED8AA4A;
            6'd54:   r = 32'h5B9CCA4F;
            6'd55:   r = 32'h682E6FF3;
            6'd56:   r = 32'h748F82EE;
            6'd57:   r = 32'h78A5636F;
            6'd58:   r = 32'h84C87814;
            6'd59:   r = 32'h8CC70208;
            6'd60:   r = 32'h90BEFFFA;
            6'd61:   r = 32'hA4506CEB;
            6'd62:   r = 32'hBEF9A3F7;
            default: r = 32'hC67178F2;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sha256_digest.sv =====
// sha256_digest: sha-256 hash of a byte message
//
// input stream (s_*): one transaction per message item. s_tuser = 0 absorbs the
// byte in s_tdata, s_tuser = 1 finishes the message (s_tdata ignored).
// output stream (m_*): eight transactions per finished message, hash words
// 0..7 in order, word index beside the word, m_tlast on word 7.
//
// the 64th byte of a block starts the compression: 64 rounds on one shared
// round unit, one round per cycle, then a fold of the result into the hash;
// s_tready is low throughout. a finish feeds the padding bytes through the
// same byte path, one per cycle: with f bytes in the open block, f < 56 pads
// and compresses one block, f >= 56 two blocks, before word 0 appears.
// the digest words are held in an output register; while the receiver stalls
// the current word holds and no new message item is taken. after word 7 the
// block is back at the initial hash with an empty message.
// reset clears the hash to its initial values, the byte and length counters to
// zero, and leaves the block ready for the first item.
module sha256_digest (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sha256d_pkg::S_TDATA_W-1:0]   s_tdata,   // data_byte
    input  logic                                s_tuser,   // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sha256d_pkg::M_TDATA_W-1:0]   m_tdata,   // digest_word, word_index
    output logic                                m_tlast    // last_word
);

    import sha256d_pkg::*;

    state_t       state_reg,  state_next;
    logic [511:0] win_reg,    win_next;
    words8_t      v_reg,      v_next;
    words8_t      hash_reg,   hash_next;
    logic [5:0]   fill_reg,   fill_next;
    logic [60:0]  total_reg,  total_next;
    logic [63:0]  len_reg,    len_next;
    logic [5:0]   round_reg,  round_next;
    logic [2:0]   idx_reg,    idx_next;
    logic         pad_reg,    pad_next;
    logic         len_ok_reg, len_ok_next;
    logic         first_reg,  first_next;

    logic         take_byte;
    logic [7:0]   byte_val;
    logic         len_byte;
    logic [31:0]  w_val;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  choose;
    logic [31:0]  major;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'b0, idx_reg, hash_reg[0]};
    assign m_tlast  = (idx_reg == LAST_IDX);

    // round unit
    always_comb
    begin
        if (round_reg < SCHED_POS)
        begin
            w_val = win_reg[511:480];
        end
        else
        begin
            w_val = win_reg[511:480] + small_sig0(win_reg[479:448])
                  + win_reg[223:192] + small_sig1(win_reg[63:32]);
        end
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big_sig1(v_reg[4]) + choose + round_k(round_reg) + w_val;
        t2     = big_sig0(v_reg[0]) + major;
    end

    assign len_byte = !first_reg && len_ok_reg && (fill_reg >= LEN_POS);

    always_comb
    begin
        state_next  = state_reg;
        win_next    = win_reg;
        v_next      = v_reg;
        hash_next   = hash_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;
        len_next    = len_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        pad_next    = pad_reg;
        len_ok_next = len_ok_reg;
        first_next  = first_reg;
        take_byte   = 1'b0;
        byte_val    = s_tdata;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ACT_ABSORB)
                    begin
                        take_byte  = 1'b1;
                        total_next = total_reg + 61'd1;
                    end
                    else
                    begin
                        len_next    = {total_reg, 3'b000};
                        total_next  = '0;
                        pad_next    = 1'b1;
                        first_next  = 1'b1;
                        len_ok_next = (fill_reg < LEN_POS);
                        state_next  = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                take_byte  = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    byte_val = PAD_MARK;
                end
                else if (len_byte)
                begin
                    byte_val = len_reg[63:56];
                    len_next = {len_reg[55:0], 8'h00};
                end
                else
                begin
                    byte_val = 8'h00;
                end
            end
            S_ROUND:
            begin
                win_next   = {win_reg[479:0], w_val};
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_POS)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                if (!pad_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (len_ok_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = S_PAD;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        hash_next[i] = hash_reg[i+1];
                    end
                    hash_next[7] = initial_hash(idx_reg);
                    idx_next     = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        pad_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shared byte path for message and padding bytes
        if (take_byte)
        begin
            win_next  = {win_reg[503:0], byte_val};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_POS)
            begin
                v_next     = hash_reg;
                round_next = '0;
                state_next = S_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            total_reg  <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            pad_reg    <= 1'b0;
            len_ok_reg <= 1'b0;
            first_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= initial_hash(3'(i));
            end
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            total_reg  <= total_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            pad_reg    <= pad_next;
            len_ok_reg <= len_ok_next;
            first_reg  <= first_next;
            hash_reg   <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        v_reg   <= v_next;
        len_reg <= len_next;
    end

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest output pending");

    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ROUND) |-> (round_reg == 6'd0))
        else $error("round counter not at zero outside compression");

    a_out_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (fill_reg == 6'd0 && pad_reg && len_ok_reg))
        else $error("digest output without a closed final block");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=>
            (s_tready && hash_reg[0] == initial_hash(3'd0) && total_reg == 61'd0))
        else $error("hash not back at initial values after digest");

endmodule
